// ----- rtl/stpr_pkg.sv -----
// ----------------------------------------------------------------------------
// stpr_pkg
// Types and constants shared by the trapezoid ramp generator and its testbench.
// ----------------------------------------------------------------------------
package stpr_pkg;

  typedef struct packed {
    logic        mode;
    logic [31:0] move_steps;
  } in_item_t;

  typedef struct packed {
    logic [31:0] period_load;
    logic        stepped;
    logic [3:0]  coil_pattern;
    logic [31:0] motor_position;
    logic [1:0]  ramp_phase;
    logic        timer_on;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_MINP,
    ST_QARG,
    ST_ROOT,
    ST_R100,
    ST_C0,
    ST_LIMM,
    ST_LIMD,
    ST_MAXL,
    ST_ACCL,
    ST_DECC,
    ST_EMIT
  } seq_state_t;

  localparam logic [1:0] PH_STOP  = 2'd0;
  localparam logic [1:0] PH_ACCEL = 2'd1;
  localparam logic [1:0] PH_DECEL = 2'd2;
  localparam logic [1:0] PH_RUN   = 2'd3;

  localparam logic [1:0] REG_ACCEL = 2'd0;
  localparam logic [1:0] REG_DECEL = 2'd1;
  localparam logic [1:0] REG_SPEED = 2'd2;

  localparam logic [31:0] SPEED_NUM      = 32'd6283180;
  localparam logic [31:0] C0_SCALE       = 32'd135;
  localparam logic [31:0] SQRT_ARG       = 32'd628318000;
  localparam logic [31:0] LIM_SCALE      = 32'd628;
  localparam logic [31:0] ONE_STEP_DELAY = 32'd1000;
  // x / 100 == (x * RECIP_100) >> 37 for any 32-bit x
  localparam logic [31:0] RECIP_100      = 32'd1374389535;

  function automatic logic [3:0] coil_lookup(input logic [1:0] idx);
    logic [3:0] pat;
    case (idx)
      2'd0: pat = 4'd9;
      2'd1: pat = 4'd5;
      2'd2: pat = 4'd6;
      default: pat = 4'd10;
    endcase
    return pat;
  endfunction

endpackage

// ----- rtl/stpr_div.sv -----
// ----------------------------------------------------------------------------
// stpr_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module stpr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quo,
  output logic [31:0] rem
);

  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        run;
  logic [32:0] r_sh;
  logic [32:0] r_sub;
  logic        ge;

  always_comb begin
    r_sh  = {rem, quo[63]};
    r_sub = r_sh - {1'b0, dvs};
    ge    = (r_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == 6'd63);
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (run) begin
      quo <= {quo[62:0], ge};
      rem <= ge ? r_sub[31:0] : r_sh[31:0];
    end
  end

endmodule

// ----- rtl/stpr_sqrt.sv -----
// ----------------------------------------------------------------------------
// stpr_sqrt
// Bitwise integer square root, rounded to nearest, two argument bits per pass.
// ----------------------------------------------------------------------------
module stpr_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] arg,
  output logic        done,
  output logic [31:0] root
);

  logic [31:0] v;
  logic [31:0] res;
  logic [31:0] bitv;
  logic        run;
  logic [31:0] trial;
  logic        take;

  always_comb begin
    trial = res + bitv;
    take  = (trial <= v);
    root  = (res < v) ? res + 32'd1 : res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (bitv == 32'd1);
      if (go) run <= 1'b1;
      else if (run && bitv == 32'd1) run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      v    <= arg;
      res  <= '0;
      bitv <= 32'h4000_0000;
    end else if (run) begin
      if (take) v <= v - trial;
      res  <= (res >> 1) + (take ? bitv : 32'd0);
      bitv <= bitv >> 2;
    end
  end

endmodule

// ----- rtl/stepper_trapezoid_ramp.sv -----
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp
// Trapezoidal stepper speed-ramp generator with a shared iterative divider.
// ----------------------------------------------------------------------------
// in channel: one item is either a timer tick (mode 0) or a move start
// (mode 1, signed step count). out channel: one result item per input item.
// Config: cfg_we writes register cfg_index (0 accel, 1 decel, 2 top speed)
// with cfg_data; write only while the block is idle.
// A tick in STOP or RUN and a start of zero or one step go straight to
// the result; a tick in ACCEL or DECEL runs one division. A start runs
// four or five divisions, one root and four multiply steps. One item is
// in flight at a time; in_ready is high only when the sequencer is idle,
// which it is again in the cycle after the result is loaded, so a new
// item is taken only when the sequencer has finished the last one. A
// finished result waits in the output register while out_ready is low,
// and the next item is accepted meanwhile. Reset clears the ramp state
// to STOP, position zero, and loads the default registers (accel 100,
// decel 1, speed 23).
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  stpr_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output stpr_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import stpr_pkg::*;

  seq_state_t state, state_next;

  logic [15:0] accel_rate, decel_rate, top_speed;
  logic [15:0] acc, dec, spd;

  logic [1:0]  phase;
  logic        dir;
  logic [31:0] cd, dss, dci, minp, rc, lap, sd, rest, pos;
  logic [1:0]  ci;

  logic [31:0] mag, first, tmp, lim_den, max_lim, period;
  logic        neg_div, stepped_r, timer_r, is_start, wait_r;

  logic        div_go, div_done, sq_go, sq_done;
  logic [63:0] div_dividend, div_quo;
  logic [31:0] div_divisor, div_rem, sq_root;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic        accept;
  logic [31:0] raw_mag, rc1, d4, d4_mag, q32, nd, lim_q, dci_f, acc_lim_n;
  logic        unit_done;

  stpr_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  stpr_sqrt u_sqrt (
    .clk(clk), .rst(rst), .go(sq_go), .arg(tmp), .done(sq_done), .root(sq_root)
  );

  always_comb begin
    acc = (accel_rate == 16'd0) ? 16'd1 : accel_rate;
    dec = (decel_rate == 16'd0) ? 16'd1 : decel_rate;
    spd = (top_speed == 16'd0) ? 16'd1 : top_speed;
    in_ready  = (state == ST_IDLE);
    accept    = in_valid && in_ready;
    raw_mag   = in_data.move_steps[31] ? 32'd0 - in_data.move_steps : in_data.move_steps;
    rc1       = rc + 32'd1;
    d4        = {rc1[29:0], 2'b00} + 32'd1;
    d4_mag    = d4[31] ? 32'd0 - d4 : d4;
    q32       = div_quo[31:0];
    nd        = neg_div ? cd + q32 : cd - q32;
    lim_q     = (q32 == 32'd0) ? 32'd1 : q32;
    acc_lim_n = lim_q;
    unit_done = (state == ST_ROOT) ? sq_done : div_done;
    mul_p     = {32'd0, mul_a} * {32'd0, mul_b};
  end

  // shared multiplier and unit operands
  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    div_dividend = '0;
    div_divisor  = 32'd1;
    div_go       = 1'b0;
    sq_go        = 1'b0;
    case (state)
      ST_IDLE: begin
        div_dividend = {31'd0, cd, 1'b0} + {32'd0, rest};
        div_divisor  = d4_mag;
        div_go = accept && !in_data.mode && (phase == PH_ACCEL || phase == PH_DECEL);
      end
      ST_MINP: begin
        div_dividend = {32'd0, SPEED_NUM};
        div_divisor  = {16'd0, spd};
        div_go = !wait_r;
      end
      ST_QARG: begin
        div_dividend = {32'd0, SQRT_ARG};
        div_divisor  = {16'd0, acc};
        div_go = !wait_r;
      end
      ST_ROOT: sq_go = !wait_r;
      ST_R100: begin
        mul_a = tmp;
        mul_b = RECIP_100;
      end
      ST_C0: begin
        mul_a = C0_SCALE;
        mul_b = tmp;
      end
      ST_LIMM: begin
        mul_a = LIM_SCALE;
        mul_b = {16'd0, acc};
      end
      ST_LIMD: begin
        mul_a = tmp;
        mul_b = RECIP_100;
      end
      ST_MAXL: begin
        mul_a = {16'd0, spd};
        mul_b = {16'd0, spd};
        div_dividend = mul_p;
        div_divisor  = lim_den;
        div_go = !wait_r;
      end
      ST_ACCL: begin
        mul_a = mag;
        mul_b = {16'd0, dec};
        div_dividend = mul_p;
        div_divisor  = {16'd0, acc} + {16'd0, dec};
        div_go = !wait_r;
      end
      ST_DECC: begin
        mul_a = max_lim;
        mul_b = {16'd0, acc};
        div_dividend = mul_p;
        div_divisor  = {16'd0, dec};
        div_go = !wait_r;
      end
      default: ;
    endcase
    if (state == ST_ACCL && acc_lim_n <= max_lim) dci_f = acc_lim_n - mag;
    else dci_f = 32'd0 - q32;
    if (dci_f == 32'd0) dci_f = 32'hFFFF_FFFF;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!in_data.mode) begin
            state_next = (phase == PH_ACCEL || phase == PH_DECEL) ? ST_TICK : ST_EMIT;
          end else if (raw_mag == 32'd0 || raw_mag == 32'd1) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_MINP;
          end
        end
      end
      ST_TICK: if (wait_r && unit_done) state_next = ST_EMIT;
      ST_MINP: if (wait_r && unit_done) state_next = ST_QARG;
      ST_QARG: if (wait_r && unit_done) state_next = ST_ROOT;
      ST_ROOT: if (wait_r && unit_done) state_next = ST_R100;
      ST_R100: state_next = ST_C0;
      ST_C0:   state_next = ST_LIMM;
      ST_LIMM: state_next = ST_LIMD;
      ST_LIMD: state_next = ST_MAXL;
      ST_MAXL: if (wait_r && unit_done) state_next = ST_ACCL;
      ST_ACCL: begin
        if (wait_r && unit_done) state_next = (acc_lim_n <= max_lim) ? ST_EMIT : ST_DECC;
      end
      ST_DECC: if (wait_r && unit_done) state_next = ST_EMIT;
      ST_EMIT: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      accel_rate <= 16'd100;
      decel_rate <= 16'd1;
      top_speed  <= 16'd23;
      phase      <= PH_STOP;
      dir        <= 1'b0;
      cd         <= '0;
      dss        <= '0;
      dci        <= '0;
      minp       <= '0;
      rc         <= '0;
      lap        <= '0;
      sd         <= '0;
      rest       <= '0;
      pos        <= '0;
      ci         <= '0;
      wait_r     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_ACCEL: accel_rate <= cfg_data;
          REG_DECEL: decel_rate <= cfg_data;
          REG_SPEED: top_speed  <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (div_go || sq_go) wait_r <= 1'b1;
      else if (wait_r && unit_done) wait_r <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (accept) begin
            is_start <= in_data.mode;
            period   <= cd;
            if (in_data.mode) begin
              stepped_r <= 1'b0;
              timer_r   <= 1'b1;
              dir       <= in_data.move_steps[31];
              mag       <= raw_mag;
              if (raw_mag == 32'd1) begin
                rc    <= 32'hFFFF_FFFF;
                phase <= PH_DECEL;
                cd    <= ONE_STEP_DELAY;
              end
            end else if (phase == PH_STOP) begin
              stepped_r <= 1'b0;
              timer_r   <= 1'b0;
              sd        <= '0;
              rest      <= '0;
            end else begin
              stepped_r <= 1'b1;
              timer_r   <= 1'b1;
              sd        <= sd + 32'd1;
              pos       <= dir ? pos - 32'd1 : pos + 32'd1;
              ci        <= dir ? ci - 2'd1 : ci + 2'd1;
              if (phase == PH_RUN) begin
                if (sd + 32'd1 >= dss) begin
                  rc    <= dci;
                  cd    <= lap;
                  phase <= PH_DECEL;
                end else begin
                  cd <= minp;
                end
              end else begin
                rc      <= rc1;
                neg_div <= d4[31];
              end
            end
          end
        end
        ST_TICK: begin
          if (wait_r && unit_done) begin
            rest <= div_rem;
            cd   <= nd;
            if (phase == PH_ACCEL) begin
              if (sd >= dss) begin
                rc    <= dci;
                phase <= PH_DECEL;
              end else if (nd <= minp) begin
                lap   <= nd;
                cd    <= minp;
                rest  <= '0;
                phase <= PH_RUN;
              end
            end else if (!rc[31]) begin
              phase <= PH_STOP;
            end
          end
        end
        ST_MINP: if (wait_r && unit_done) minp <= q32;
        ST_QARG: if (wait_r && unit_done) tmp <= q32;
        ST_ROOT: if (wait_r && unit_done) tmp <= sq_root;
        ST_R100: tmp <= {5'd0, mul_p[63:37]};
        ST_C0:   first <= mul_p[31:0];
        ST_LIMM: tmp <= mul_p[31:0];
        ST_LIMD: lim_den <= {5'd0, mul_p[63:37]};
        ST_MAXL: if (wait_r && unit_done) max_lim <= lim_q;
        ST_ACCL, ST_DECC: begin
          if (wait_r && unit_done && (state == ST_DECC || acc_lim_n <= max_lim)) begin
            dci <= dci_f;
            dss <= mag + dci_f;
            rc  <= '0;
            if (first <= minp) begin
              cd    <= minp;
              phase <= PH_RUN;
            end else begin
              cd    <= first;
              phase <= PH_ACCEL;
            end
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && (!out_valid || out_ready)) begin
      out_data.period_load    <= is_start ? cd : period;
      out_data.stepped        <= stepped_r;
      out_data.coil_pattern   <= coil_lookup(ci);
      out_data.motor_position <= pos;
      out_data.ramp_phase     <= phase;
      out_data.timer_on       <= timer_r;
    end
  end

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> wait_r) else $error("divider result without request");

  a_sqrt_in_root: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == ST_ROOT) else $error("root result outside root step");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && (!out_valid || out_ready) |=> out_valid)
    else $error("result item not loaded");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(div_go && sq_go)) else $error("two units started together");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stepper_trapezoid_ramp. A queue of start and tick
// items feeds a valid/ready driver; a predictor of the ramp computes each
// expected result at acceptance, and a monitor compares every result item
// field by field. Runs several register settings, random idling on both
// sides, one long output stall and a quiet final phase.
// ----------------------------------------------------------------------------
module testbench;
  import stpr_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int LONG_HOLD   = 3000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  stepper_trapezoid_ramp u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ramp model state
  logic [15:0] m_accel, m_decel, m_speed;
  logic [1:0]  m_phase;
  logic        m_dir;
  logic [31:0] m_delay, m_decel_start, m_decel_init, m_min_period;
  logic [31:0] m_counter, m_last_accel, m_steps, m_rest, m_pos;
  logic [1:0]  m_coil;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int errors;
  int cycles;
  bit calm;
  int gap_cnt;
  int stall_cnt;
  int holds_asked, holds_done;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic logic [31:0] nonzero(logic [15:0] v);
    return (v == 16'd0) ? 32'd1 : {16'd0, v};
  endfunction

  function automatic logic [63:0] root_rnd(logic [63:0] v);
    logic [63:0] r, b;
    bit take;
    r = '0;
    b = 64'h40000000;
    while (b != 0) begin
      take = (r + b) <= v;
      if (take) v = v - (r + b);
      r = r >> 1;
      if (take) r = r + b;
      b = b >> 2;
    end
    return (r < v) ? r + 64'd1 : r;
  endfunction

  function automatic void step_coil();
    if (!m_dir) begin
      m_pos = m_pos + 32'd1;
      m_coil = m_coil + 2'd1;
    end else begin
      m_pos = m_pos - 32'd1;
      m_coil = m_coil - 2'd1;
    end
  endfunction

  function automatic logic [31:0] recur_delay();
    logic [63:0] num, mag;
    logic [31:0] d, q;
    num = 2 * 64'(m_delay) + 64'(m_rest);
    d = 4 * m_counter + 1;
    mag = d[31] ? 64'(32'(0 - d)) : 64'(d);
    q = 32'(num / mag);
    m_rest = 32'(num % mag);
    return d[31] ? m_delay + q : m_delay - q;
  endfunction

  function automatic void begin_move(logic [31:0] raw);
    logic [31:0] acc, dec, spd, mag, maxl, accl, first;
    acc = nonzero(m_accel);
    dec = nonzero(m_decel);
    spd = nonzero(m_speed);
    m_dir = raw[31];
    mag = raw[31] ? 0 - raw : raw;
    if (mag == 0) return;
    if (mag == 1) begin
      m_counter = 32'hFFFFFFFF;
      m_phase = PH_DECEL;
      m_delay = ONE_STEP_DELAY;
      return;
    end
    m_min_period = SPEED_NUM / spd;
    first = 32'(64'(C0_SCALE) * (root_rnd(64'(SQRT_ARG / acc)) / 100));
    maxl = 32'((64'(spd) * spd) / ((64'(LIM_SCALE) * acc) / 100));
    if (maxl == 0) maxl = 1;
    accl = 32'((64'(mag) * dec) / (64'(acc) + dec));
    if (accl == 0) accl = 1;
    if (accl <= maxl) m_decel_init = accl - mag;
    else m_decel_init = 0 - 32'((64'(maxl) * acc) / dec);
    if (m_decel_init == 0) m_decel_init = 32'hFFFFFFFF;
    m_decel_start = mag + m_decel_init;
    if (first <= m_min_period) begin
      m_delay = m_min_period;
      m_phase = PH_RUN;
    end else begin
      m_delay = first;
      m_phase = PH_ACCEL;
    end
    m_counter = 0;
  endfunction

  function automatic out_item_t ramp_result(in_item_t it);
    out_item_t r;
    logic [31:0] nd;
    r = '0;
    r.timer_on = 1'b1;
    if (it.mode) begin
      begin_move(it.move_steps);
      r.period_load = m_delay;
    end else begin
      nd = m_delay;
      r.period_load = m_delay;
      case (m_phase)
        PH_STOP: begin
          m_steps = 0;
          m_rest = 0;
          r.timer_on = 1'b0;
        end
        PH_ACCEL: begin
          step_coil();
          r.stepped = 1'b1;
          m_steps = m_steps + 1;
          m_counter = m_counter + 1;
          nd = recur_delay();
          if (m_steps >= m_decel_start) begin
            m_counter = m_decel_init;
            m_phase = PH_DECEL;
          end else if (nd <= m_min_period) begin
            m_last_accel = nd;
            nd = m_min_period;
            m_rest = 0;
            m_phase = PH_RUN;
          end
        end
        PH_RUN: begin
          step_coil();
          r.stepped = 1'b1;
          m_steps = m_steps + 1;
          nd = m_min_period;
          if (m_steps >= m_decel_start) begin
            m_counter = m_decel_init;
            nd = m_last_accel;
            m_phase = PH_DECEL;
          end
        end
        default: begin
          step_coil();
          r.stepped = 1'b1;
          m_steps = m_steps + 1;
          m_counter = m_counter + 1;
          nd = recur_delay();
          if (!m_counter[31]) m_phase = PH_STOP;
        end
      endcase
      m_delay = nd;
    end
    r.coil_pattern = (m_coil == 2'd0) ? 4'd9 : (m_coil == 2'd1) ? 4'd5 :
                     (m_coil == 2'd2) ? 4'd6 : 4'd10;
    r.motor_position = m_pos;
    r.ramp_phase = m_phase;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(ramp_result(in_data));
      if (in_valid && !in_ready) begin
      end else if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        gap_cnt <= $urandom_range(1, 9) - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_cnt <= 0;
    end else if (holds_asked != holds_done) begin
      holds_done <= holds_asked;
      stall_cnt <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_cnt <= $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("unexpected result item");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.period_load != e.period_load)
          report("period_load", out_data.period_load, e.period_load);
        if (out_data.stepped != e.stepped)
          report("stepped", 32'(out_data.stepped), 32'(e.stepped));
        if (out_data.coil_pattern != e.coil_pattern)
          report("coil_pattern", 32'(out_data.coil_pattern), 32'(e.coil_pattern));
        if (out_data.motor_position != e.motor_position)
          report("motor_position", out_data.motor_position, e.motor_position);
        if (out_data.ramp_phase != e.ramp_phase)
          report("ramp_phase", 32'(out_data.ramp_phase), 32'(e.ramp_phase));
        if (out_data.timer_on != e.timer_on)
          report("timer_on", 32'(out_data.timer_on), 32'(e.timer_on));
      end
    end
  end

  task automatic add_tick();
    in_item_t it;
    it.mode = 1'b0;
    it.move_steps = $urandom;
    pending_items.push_back(it);
  endtask

  task automatic add_start(logic [31:0] steps);
    in_item_t it;
    it.mode = 1'b1;
    it.move_steps = steps;
    pending_items.push_back(it);
  endtask

  task automatic add_ticks(int n);
    repeat (n) add_tick();
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_ACCEL: m_accel = v;
      REG_DECEL: m_decel = v;
      default:   m_speed = v;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [15:0] a, logic [15:0] d, logic [15:0] s);
    write_reg(REG_ACCEL, a);
    write_reg(REG_DECEL, d);
    write_reg(REG_SPEED, s);
  endtask

  // random moves, mostly complete; some cut short or with wild counts
  task automatic random_moves(int n_items);
    int sent, mag, kind;
    logic [31:0] steps;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 19);
      mag = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 300) : $urandom_range(0, 40);
      steps = $urandom_range(0, 1) ? -mag : mag;
      if (kind == 0) steps = $urandom;
      add_start(steps);
      if (kind < 3) mag = $urandom_range(0, mag);
      else mag = mag + $urandom_range(1, 4);
      if (mag > 400) mag = 400;
      add_ticks(mag);
      sent += mag + 1;
      if (pending_items.size() > 200) wait (pending_items.size() < 50);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ACCEL;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    holds_asked = 0;
    holds_done = 0;
    m_accel = 16'd100; m_decel = 16'd1; m_speed = 16'd23;
    m_phase = PH_STOP; m_dir = 1'b0; m_delay = 0; m_decel_start = 0;
    m_decel_init = 0; m_min_period = 0; m_counter = 0; m_last_accel = 0;
    m_steps = 0; m_rest = 0; m_pos = 0; m_coil = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed, default registers
    add_tick();
    add_start(32'd0);
    add_start(32'd1);
    add_ticks(2);
    add_start(-32'sd1);
    add_ticks(2);
    add_start(32'd4);
    add_ticks(6);
    add_start(32'h7FFFFFFF);
    add_ticks(2);
    add_start(32'h80000000);
    add_ticks(2);
    add_start(-32'sd3);
    add_ticks(5);
    drain();

    // fill the block while the output is held off
    holds_asked = 1;
    random_moves(40);
    drain();

    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_moves(350);
    drain();

    set_regs(16'd1, 16'd1, 16'd1);
    random_moves(200);
    drain();

    set_regs(16'd0, 16'd0, 16'd0);
    random_moves(150);
    drain();

    set_regs(16'd200, 16'd300, 16'd5000);
    random_moves(350);
    drain();

    set_regs(16'($urandom), 16'($urandom), 16'($urandom));
    calm = 1'b1;
    random_moves(350);
    drain();

    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/stpr_pkg.sv
rtl/stpr_div.sv
rtl/stpr_sqrt.sv
rtl/stepper_trapezoid_ramp.sv
tb/testbench.sv
